// ===== rtl/acl_pkg.sv =====
// Shared constants, codes and types of the address cache learn block.
package acl_pkg;

  // Table geometry and field widths.
  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned MAC_BITS  = 48;
  localparam int unsigned NODE_W    = 8;
  localparam int unsigned PORT_W    = 8;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TTL_W     = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned INDEX_W   = 4;
  localparam int unsigned SLOT_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(300);

  // Result codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_FOUND   = 2'd0,
    STATUS_WRITTEN = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic              found;
    logic              have_free;
    logic [SLOT_W-1:0] slot;
  } scan_tok_t;

  // Write command broadcast to all cells at the end of a scan.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
  } wr_ctl_t;

endpackage

// ===== rtl/acl_req_if.sv =====
// Learn request channel: valid, ready and the request fields.
interface acl_req_if;
  logic                          valid;
  logic                          ready;
  logic [acl_pkg::NODE_W-1:0]    node_address;
  logic [acl_pkg::MAC_BITS-1:0]  mac_address;
  logic [acl_pkg::PORT_W-1:0]    port_id;
  logic [acl_pkg::TIME_W-1:0]    current_time;

  modport source (output valid, node_address, mac_address, port_id, current_time,
                  input ready);
  modport sink (input valid, node_address, mac_address, port_id, current_time,
                output ready);
endinterface

// ===== rtl/acl_rsp_if.sv =====
// Learn result channel: valid, ready and the result fields.
interface acl_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [acl_pkg::STATUS_W-1:0]  status;
  logic [acl_pkg::INDEX_W-1:0]   entry_index;

  modport source (output valid, status, entry_index, input ready);
  modport sink (input valid, status, entry_index, output ready);
endinterface

// ===== rtl/acl_cell.sv =====
// One table entry with its age check and node compare; passes the scan token on.
module acl_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [acl_pkg::SLOT_W-1:0]    cell_idx_i,
  input  logic [acl_pkg::TTL_W-1:0]     ttl_i,
  input  logic [acl_pkg::NODE_W-1:0]    node_i,
  input  logic [acl_pkg::MAC_BITS-1:0]  mac_i,
  input  logic [acl_pkg::PORT_W-1:0]    port_i,
  input  logic [acl_pkg::TIME_W-1:0]    time_i,
  input  acl_pkg::wr_ctl_t              wr_i,
  input  acl_pkg::scan_tok_t            tok_i,
  output acl_pkg::scan_tok_t            tok_o
);

  logic [acl_pkg::NODE_W-1:0]   node_q;
  logic [acl_pkg::MAC_BITS-1:0] mac_q;
  logic [acl_pkg::PORT_W-1:0]   port_q;
  logic [acl_pkg::TIME_W-1:0]   stamp_q;
  acl_pkg::scan_tok_t           tok_q, tok_d;

  logic [acl_pkg::TIME_W-1:0]   age;
  logic                         expired;
  logic                         active;
  logic                         wr_hit;
  logic                         clr_hit;

  // Age check; the difference wraps and is compared unsigned.
  assign age     = time_i - stamp_q;
  assign expired = (age > ttl_i);
  assign active  = tok_i.valid && !tok_i.found;
  assign wr_hit  = wr_i.en && (wr_i.slot == cell_idx_i);
  assign clr_hit = active && expired && (stamp_q == '0);

  // Update the token: first expired entry becomes the free slot, a live match ends the scan.
  always_comb begin
    tok_d = tok_i;
    if (active) begin
      if (expired) begin
        if (!tok_i.have_free) begin
          tok_d.have_free = 1'b1;
          tok_d.slot      = cell_idx_i;
        end
      end else if (node_q == node_i) begin
        tok_d.found = 1'b1;
        tok_d.slot  = cell_idx_i;
      end
    end
  end

  // Entry storage; an expired entry that was never stamped is wiped as it is scanned.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q  <= '0;
      mac_q   <= '0;
      port_q  <= '0;
      stamp_q <= '0;
    end else if (wr_hit) begin
      node_q  <= node_i;
      mac_q   <= mac_i;
      port_q  <= port_i;
      stamp_q <= time_i;
    end else if (clr_hit) begin
      node_q  <= '0;
      mac_q   <= '0;
      port_q  <= '0;
    end
  end

  // Token register toward the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/address_cache_learn_with_aging_core.sv =====
// Top level of the address cache learn block with entry aging.
//
//   channel  direction  handshake      payload
//   req_i    in         valid/ready    node_address, mac_address, port_id, current_time
//   rsp_o    out        valid/ready    status, entry_index
//   cfg      in         cfg_we_i       cfg_wdata_i (ttl_seconds)
//
// A request runs through the row of ENTRIES cells, one cell per cycle, and the
// result is registered from the token that leaves the last cell, together with
// the write of a new entry. One request is in flight at a time; the next one is
// taken only after its predecessor's token has left the last cell. While the
// sink stalls, one further result is parked in a spare register, and the input
// also stalls while it is full.
// Reset clears all entries at once and loads the TTL with 300.
module address_cache_learn_with_aging_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [acl_pkg::TTL_W-1:0]   cfg_wdata_i,
  acl_req_if.sink                     req_i,
  acl_rsp_if.source                   rsp_o
);

  logic [acl_pkg::TTL_W-1:0]    ttl_q;
  logic                         busy_q;
  logic                         start_q;
  logic                         out_valid_q;
  acl_pkg::status_e             status_q;
  logic [acl_pkg::INDEX_W-1:0]  index_q;
  logic                         spare_valid_q;
  acl_pkg::status_e             spare_status_q;
  logic [acl_pkg::INDEX_W-1:0]  spare_index_q;

  logic [acl_pkg::NODE_W-1:0]   node_q;
  logic [acl_pkg::MAC_BITS-1:0] mac_q;
  logic [acl_pkg::PORT_W-1:0]   port_q;
  logic [acl_pkg::TIME_W-1:0]   time_q;

  acl_pkg::scan_tok_t           tok [acl_pkg::ENTRIES+1];
  acl_pkg::scan_tok_t           last_tok;
  acl_pkg::wr_ctl_t             wr;
  logic                         accept;
  logic                         rsp_take;
  acl_pkg::status_e             res_status;
  logic [acl_pkg::INDEX_W-1:0]  res_index;

  // Handshake on the request side.
  assign req_i.ready = !busy_q && !spare_valid_q;
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_take    = out_valid_q && rsp_o.ready;

  // TTL register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q <= acl_pkg::TTL_RESET;
    end else if (cfg_we_i) begin
      ttl_q <= cfg_wdata_i;
    end
  end

  // Request fields held for the whole scan.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      node_q <= req_i.node_address;
      mac_q  <= req_i.mac_address;
      port_q <= req_i.port_id;
      time_q <= req_i.current_time;
    end
  end

  // Token entering the first cell.
  always_comb begin
    tok[0]           = '0;
    tok[0].valid     = start_q;
  end

  // Row of entry cells.
  for (genvar k = 0; k < acl_pkg::ENTRIES; k++) begin : g_cell
    acl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (acl_pkg::SLOT_W'(k)),
      .ttl_i      (ttl_q),
      .node_i     (node_q),
      .mac_i      (mac_q),
      .port_i     (port_q),
      .time_i     (time_q),
      .wr_i       (wr),
      .tok_i      (tok[k]),
      .tok_o      (tok[k+1])
    );
  end

  // Write the request into the free slot when the scan found no live match.
  assign last_tok = tok[acl_pkg::ENTRIES];
  assign wr.en    = last_tok.valid && !last_tok.found && last_tok.have_free;
  assign wr.slot  = last_tok.slot;

  // Result of the scan that leaves the last cell.
  always_comb begin
    if (last_tok.found) begin
      res_status = acl_pkg::STATUS_FOUND;
      res_index  = acl_pkg::INDEX_W'(last_tok.slot);
    end else if (last_tok.have_free) begin
      res_status = acl_pkg::STATUS_WRITTEN;
      res_index  = acl_pkg::INDEX_W'(last_tok.slot);
    end else begin
      res_status = acl_pkg::STATUS_FULL;
      res_index  = '0;
    end
  end

  // Control, result register and the spare result register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      start_q        <= 1'b0;
      out_valid_q    <= 1'b0;
      status_q       <= acl_pkg::STATUS_FOUND;
      index_q        <= '0;
      spare_valid_q  <= 1'b0;
      spare_status_q <= acl_pkg::STATUS_FOUND;
      spare_index_q  <= '0;
    end else begin
      start_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end
      if (last_tok.valid) begin
        busy_q <= 1'b0;
        if (!out_valid_q || rsp_take) begin
          out_valid_q <= 1'b1;
          status_q    <= res_status;
          index_q     <= res_index;
        end else begin
          spare_valid_q  <= 1'b1;
          spare_status_q <= res_status;
          spare_index_q  <= res_index;
        end
      end else if (rsp_take) begin
        if (spare_valid_q) begin
          status_q      <= spare_status_q;
          index_q       <= spare_index_q;
          spare_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.entry_index = index_q;

endmodule

// ===== rtl/acl_checker.sv =====
// Port-level checks for the address cache learn block, bound to its top level.
module acl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [acl_pkg::STATUS_W-1:0]  rsp_status_i,
  input logic [acl_pkg::INDEX_W-1:0]   rsp_index_i
);

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  // Only the three defined result codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i == acl_pkg::STATUS_FOUND) ||
                    (rsp_status_i == acl_pkg::STATUS_WRITTEN) ||
                    (rsp_status_i == acl_pkg::STATUS_FULL))
    else $error("result carries an undefined status code");

  // A full table reports index zero.
  a_full_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i == acl_pkg::STATUS_FULL)) |-> (rsp_index_i == '0))
    else $error("table full result with nonzero index");

  // Once an item is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i)
    else $error("request ready right after an accepted item");

  // No new item is taken while the scan runs through the row of cells.
  a_busy_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_ready_i [*acl_pkg::ENTRIES])
    else $error("request ready during a scan");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_index_i)))
    else $error("stalled result changed");

endmodule

bind address_cache_learn_with_aging_core acl_checker u_acl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_index_i  (rsp_o.entry_index)
);
